[design/mscg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mscg_pkg
// Shared types and constants of the multi-stop color gradient core.
// ============================================================================
package mscg_pkg;

    // Number of stop registers in the register map.
    localparam int STOP_REGS = 7;

    // Configuration register index width and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_BASE  = 3'd1;

    // Color packing inside a stop register.
    localparam int COLOR_W   = 8;
    localparam int RGB_W     = 3 * COLOR_W;
    localparam int RED_LSB   = 2 * COLOR_W;
    localparam int GREEN_LSB = COLOR_W;
    localparam int BLUE_LSB  = 0;

    // Reset colors of the heat gradient.
    localparam logic [RGB_W-1:0] COLOR_GREEN  = 24'h00FF00;
    localparam logic [RGB_W-1:0] COLOR_YELLOW = 24'hFFFF00;
    localparam logic [RGB_W-1:0] COLOR_RED    = 24'hFF0000;

    // Reset value of the stop count register.
    localparam logic [CFG_INDEX_W-1:0] STOP_COUNT_RESET = 3'd3;

    // One-hot selection of a stop.
    typedef logic [STOP_REGS-1:0] stop_oh_t;

    // Segment endpoints that travel with an item through the divider.
    typedef struct packed {
        stop_oh_t lo_oh;
        stop_oh_t hi_oh;
    } seg_tag_t;

endpackage

`default_nettype wire

[design/mscg_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mscg_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module mscg_div
    import mscg_pkg::*;
#(
    parameter int VALUE_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_ready,
    input  wire logic [VALUE_WIDTH-1:0]   in_num,
    input  wire logic [VALUE_WIDTH-1:0]   in_den,
    input  wire seg_tag_t                 in_tag,
    output      logic                     out_valid,
    input  wire logic                     out_ready,
    output      logic [FRACTION_BITS-1:0] out_quot,
    output      seg_tag_t                 out_tag
);

    // The numerator must be below the denominator, so the quotient of
    // (num << FRACTION_BITS) / den fits in FRACTION_BITS bits.

    logic                     vld_reg  [FRACTION_BITS];
    logic [VALUE_WIDTH-1:0]   rem_reg  [FRACTION_BITS];
    logic [VALUE_WIDTH-1:0]   den_reg  [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] quot_reg [FRACTION_BITS];
    seg_tag_t                 tag_reg  [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] stage_en;

    genvar s;
    generate
        for (s = 0; s < FRACTION_BITS; s++) begin : g_stage
            logic                     vld_in;
            logic [VALUE_WIDTH-1:0]   rem_in;
            logic [VALUE_WIDTH-1:0]   den_in;
            logic [FRACTION_BITS-1:0] quot_in;
            seg_tag_t                 tag_in;
            logic [VALUE_WIDTH:0]     shifted;
            logic [VALUE_WIDTH:0]     diff;
            logic                     fits;
            logic [VALUE_WIDTH-1:0]   rem_next;
            logic [FRACTION_BITS-1:0] quot_next;

            if (s == 0) begin : g_first
                assign vld_in  = in_valid;
                assign rem_in  = in_num;
                assign den_in  = in_den;
                assign quot_in = '0;
                assign tag_in  = in_tag;
            end
            else begin : g_rest
                assign vld_in  = vld_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign den_in  = den_reg[s-1];
                assign quot_in = quot_reg[s-1];
                assign tag_in  = tag_reg[s-1];
            end

            if (s == FRACTION_BITS - 1) begin : g_en_last
                assign stage_en[s] = !vld_reg[s] || out_ready;
            end
            else begin : g_en_mid
                assign stage_en[s] = !vld_reg[s] || stage_en[s+1];
            end

            assign shifted   = {rem_in, 1'b0};
            assign diff      = shifted - {1'b0, den_in};
            assign fits      = (shifted >= {1'b0, den_in});
            assign rem_next  = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            assign quot_next = {quot_in[FRACTION_BITS-2:0], fits};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (stage_en[s])
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[s] && vld_in)
                begin
                    rem_reg[s]  <= rem_next;
                    den_reg[s]  <= den_in;
                    quot_reg[s] <= quot_next;
                    tag_reg[s]  <= tag_in;
                end
            end
        end
    endgenerate

    assign in_ready  = stage_en[0];
    assign out_valid = vld_reg[FRACTION_BITS-1];
    assign out_quot  = quot_reg[FRACTION_BITS-1];
    assign out_tag   = tag_reg[FRACTION_BITS-1];

endmodule

`default_nettype wire

[design/multi_stop_color_gradient_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// multi_stop_color_gradient_core
// Piecewise-linear color gradient over two to seven programmable stops.
// ============================================================================
// The core maps each incoming value to an RGB color. The value is clamped to
// the first and last stop positions, the segment lo <= value < hi is found,
// the fraction f = ((value - lo) << FRACTION_BITS) / (hi - lo) is formed with
// truncation, and each channel is blended as ((1 - f) * c_lo + f * c_hi)
// with halves rounding up. A value at the last stop gives the last color.
// The core accepts one transaction per clock cycle while in_stall is low and
// returns one result transaction per input, in order. The fraction divider
// resolves one quotient bit per pipeline stage. Every stage has its own
// valid bit and moves whenever the stage after it is empty or moving, so
// bubbles collapse and a stalled output does not stop the input while empty
// stages remain. Stop registers are written through the configuration port,
// which is always ready; writes are meant to happen while no transaction is
// in flight. After reset the stops form a green, yellow, red heat gradient.
// ============================================================================
module multi_stop_color_gradient_core
    import mscg_pkg::*;
#(
    parameter int MAX_STOPS     = 7,
    parameter int VALUE_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [RGB_W+VALUE_WIDTH-1:0]  cfg_data,
    // Input channel.
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [VALUE_WIDTH-1:0]        value,
    // Output channel.
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [COLOR_W-1:0]            red,
    output      logic [COLOR_W-1:0]            green,
    output      logic [COLOR_W-1:0]            blue
);

    localparam int STOP_W = RGB_W + VALUE_WIDTH;
    localparam int PROD_W = FRACTION_BITS + COLOR_W + 2;
    localparam logic [CFG_INDEX_W-1:0] MIN_N = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] MAX_N = CFG_INDEX_W'(MAX_STOPS);
    localparam logic [PROD_W-1:0] ROUND_HALF =
        {{(COLOR_W + 2){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CFG_INDEX_W-1:0] stop_count_reg;
    logic [STOP_W-1:0]      stops_reg [STOP_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= STOP_COUNT_RESET;
            stops_reg[0]   <= {{VALUE_WIDTH{1'b0}}, COLOR_GREEN};
            stops_reg[1]   <= {1'b1, {(VALUE_WIDTH-1){1'b0}}, COLOR_YELLOW};
            stops_reg[2]   <= {{VALUE_WIDTH{1'b1}}, COLOR_RED};
            for (int k = 3; k < STOP_REGS; k++)
            begin
                stops_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_data[CFG_INDEX_W-1:0];
            end
            for (int k = 0; k < STOP_REGS; k++)
            begin
                if (cfg_index == REG_STOP_BASE + CFG_INDEX_W'(k))
                begin
                    stops_reg[k] <= cfg_data;
                end
            end
        end
    end

    // Effective stop count and masks for all stages. The user must keep the
    // configuration static while transactions are in flight (not enforced).
    logic [CFG_INDEX_W-1:0] n_eff;
    stop_oh_t               active_mask;
    stop_oh_t               last_oh;
    logic [VALUE_WIDTH-1:0] stop_pos [STOP_REGS];

    always_comb
    begin
        if (stop_count_reg < MIN_N)
        begin
            n_eff = MIN_N;
        end
        else if (stop_count_reg > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = stop_count_reg;
        end
        for (int k = 0; k < STOP_REGS; k++)
        begin
            active_mask[k] = (CFG_INDEX_W'(k) < n_eff);
            last_oh[k]     = (CFG_INDEX_W'(k) == n_eff - 3'd1);
            stop_pos[k]    = stops_reg[k][STOP_W-1:RGB_W];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage advances when it is empty or when the
    // stage after it advances.
    // ------------------------------------------------------------------
    logic s1_vld_reg;
    logic s2_vld_reg;
    logic s3_vld_reg;
    logic b1_vld_reg;
    logic out_vld_reg;
    logic div_in_ready;
    logic div_out_valid;
    logic out_en;
    logic b1_en;
    logic s3_en;
    logic s2_en;
    logic s1_en;

    assign out_en   = !out_vld_reg || !out_stall;
    assign b1_en    = !b1_vld_reg || out_en;
    assign s3_en    = !s3_vld_reg || div_in_ready;
    assign s2_en    = !s2_vld_reg || s3_en;
    assign s1_en    = !s1_vld_reg || s2_en;
    assign in_stall = !s1_en;

    // ------------------------------------------------------------------
    // Stage 1: clamp the value to the first and last stop positions.
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] s1_value_reg;
    logic [VALUE_WIDTH-1:0] pos_last;
    logic [VALUE_WIDTH-1:0] raised;
    logic [VALUE_WIDTH-1:0] s1_value_next;

    always_comb
    begin
        pos_last = '0;
        for (int k = 0; k < STOP_REGS; k++)
        begin
            pos_last = pos_last | (last_oh[k] ? stop_pos[k] : '0);
        end
        raised        = (value < stop_pos[0]) ? stop_pos[0] : value;
        s1_value_next = (raised > pos_last) ? pos_last : raised;
    end

    // ------------------------------------------------------------------
    // Stage 2: find the first used stop above the value.
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] s2_value_reg;
    seg_tag_t               s2_tag_reg;
    logic                   s2_zero_reg;
    stop_oh_t               above;
    stop_oh_t               first_above;
    seg_tag_t               s2_tag_next;
    logic                   s2_zero_next;

    always_comb
    begin
        above[0] = 1'b0;
        for (int k = 1; k < STOP_REGS; k++)
        begin
            above[k] = active_mask[k] && (stop_pos[k] > s1_value_reg);
        end
        first_above = above & (~above + stop_oh_t'(1));
        if (above == '0)
        begin
            // The value sits at the last stop: blend with a zero fraction.
            s2_tag_next.lo_oh = last_oh;
            s2_tag_next.hi_oh = last_oh;
            s2_zero_next      = 1'b1;
        end
        else
        begin
            s2_tag_next.lo_oh = first_above >> 1;
            s2_tag_next.hi_oh = first_above;
            s2_zero_next      = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: form the divider operands.
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] s3_num_reg;
    logic [VALUE_WIDTH-1:0] s3_den_reg;
    seg_tag_t               s3_tag_reg;
    logic [VALUE_WIDTH-1:0] pos_lo;
    logic [VALUE_WIDTH-1:0] pos_hi;
    logic                   zero_frac;
    logic [VALUE_WIDTH-1:0] s3_num_next;
    logic [VALUE_WIDTH-1:0] s3_den_next;

    always_comb
    begin
        pos_lo = '0;
        pos_hi = '0;
        for (int k = 0; k < STOP_REGS; k++)
        begin
            pos_lo = pos_lo | (s2_tag_reg.lo_oh[k] ? stop_pos[k] : '0);
            pos_hi = pos_hi | (s2_tag_reg.hi_oh[k] ? stop_pos[k] : '0);
        end
        // A value below the lower stop only happens with unordered stops;
        // it takes the lower color.
        zero_frac = s2_zero_reg || (s2_value_reg < pos_lo);
        if (zero_frac)
        begin
            s3_num_next = '0;
            s3_den_next = VALUE_WIDTH'(1);
        end
        else
        begin
            s3_num_next = s2_value_reg - pos_lo;
            s3_den_next = pos_hi - pos_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_vld_reg <= in_valid;
            end
            if (s2_en)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s3_en)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            s1_value_reg <= s1_value_next;
        end
        if (s2_en && s1_vld_reg)
        begin
            s2_value_reg <= s1_value_reg;
            s2_tag_reg   <= s2_tag_next;
            s2_zero_reg  <= s2_zero_next;
        end
        if (s3_en && s2_vld_reg)
        begin
            s3_num_reg <= s3_num_next;
            s3_den_reg <= s3_den_next;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Fraction divider.
    // ------------------------------------------------------------------
    logic [FRACTION_BITS-1:0] div_quot;
    seg_tag_t                 div_tag;

    mscg_div #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .in_ready  (div_in_ready),
        .in_num    (s3_num_reg),
        .in_den    (s3_den_reg),
        .in_tag    (s3_tag_reg),
        .out_valid (div_out_valid),
        .out_ready (b1_en),
        .out_quot  (div_quot),
        .out_tag   (div_tag)
    );

    // ------------------------------------------------------------------
    // Blend stage 1: f * (c_hi - c_lo) per channel.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0]       b1_base_reg [3];
    logic [PROD_W-1:0]        b1_prod_reg [3];
    logic [RGB_W-1:0]         rgb_lo;
    logic [RGB_W-1:0]         rgb_hi;
    logic [COLOR_W-1:0]       chan_lo   [3];
    logic [COLOR_W-1:0]       chan_hi   [3];
    logic signed [COLOR_W:0]  chan_diff [3];
    logic signed [PROD_W-1:0] prod_next [3];

    always_comb
    begin
        rgb_lo = '0;
        rgb_hi = '0;
        for (int k = 0; k < STOP_REGS; k++)
        begin
            rgb_lo = rgb_lo | (div_tag.lo_oh[k] ? stops_reg[k][RGB_W-1:0] : '0);
            rgb_hi = rgb_hi | (div_tag.hi_oh[k] ? stops_reg[k][RGB_W-1:0] : '0);
        end
        chan_lo[0] = rgb_lo[RED_LSB   +: COLOR_W];
        chan_lo[1] = rgb_lo[GREEN_LSB +: COLOR_W];
        chan_lo[2] = rgb_lo[BLUE_LSB  +: COLOR_W];
        chan_hi[0] = rgb_hi[RED_LSB   +: COLOR_W];
        chan_hi[1] = rgb_hi[GREEN_LSB +: COLOR_W];
        chan_hi[2] = rgb_hi[BLUE_LSB  +: COLOR_W];
        for (int c = 0; c < 3; c++)
        begin
            chan_diff[c] = $signed({1'b0, chan_hi[c]}) - $signed({1'b0, chan_lo[c]});
            prod_next[c] = PROD_W'($signed({1'b0, div_quot})) * PROD_W'(chan_diff[c]);
        end
    end

    // ------------------------------------------------------------------
    // Blend stage 2: c_lo * 2^FB + product + half, then drop the fraction.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;
    logic [PROD_W-1:0]  blend_sum [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            blend_sum[c] = {2'b00, b1_base_reg[c], {FRACTION_BITS{1'b0}}}
                           + b1_prod_reg[c] + ROUND_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (b1_en)
            begin
                b1_vld_reg <= div_out_valid;
            end
            if (out_en)
            begin
                out_vld_reg <= b1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_en && div_out_valid)
        begin
            for (int c = 0; c < 3; c++)
            begin
                b1_base_reg[c] <= chan_lo[c];
                b1_prod_reg[c] <= prod_next[c];
            end
        end
        if (out_en && b1_vld_reg)
        begin
            red_reg   <= blend_sum[0][FRACTION_BITS +: COLOR_W];
            green_reg <= blend_sum[1][FRACTION_BITS +: COLOR_W];
            blue_reg  <= blend_sum[2][FRACTION_BITS +: COLOR_W];
        end
    end

    assign out_valid = out_vld_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

[test/multi_stop_color_gradient_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// multi_stop_color_gradient_core_tb
// Self-checking testbench of the multi-stop color gradient core.
// ============================================================================
// A queue of pending values feeds a clocked driver on the input channel. Each
// value that the core accepts is run through a color predictor that holds its
// own copy of the stop registers, and the predicted color waits in a store of
// expected colors. A clocked monitor takes every result transaction and
// compares red, green and blue with the oldest expected color.
// A short directed part covers the reset heat gradient, the ends of the value
// range, a stop count that is out of range, values below the first and above
// the last stop, stops that are not ascending and stops with equal positions.
// A long random part then goes through many stop settings, most of them
// ascending, under three flow-control regimes.
// ============================================================================
module multi_stop_color_gradient_core_tb;
    import mscg_pkg::*;

    localparam int MAX_STOPS     = 7;
    localparam int VALUE_W       = 16;
    localparam int FRAC_BITS     = 16;
    localparam int STOP_W        = RGB_W + VALUE_W;
    localparam int SEGMENTS      = 24;
    localparam int ITEMS_PER_SEG = 64;
    localparam int HOLD_SEG      = 17;
    localparam int PAUSE_SEG     = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef struct {
        logic [CFG_INDEX_W-1:0] index;
        logic [STOP_W-1:0]      data;
    } reg_write_t;

    // Clock, reset and the core's inputs start from known values.
    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [STOP_W-1:0]      cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [VALUE_W-1:0]     value     = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COLOR_W-1:0]     red;
    logic [COLOR_W-1:0]     green;
    logic [COLOR_W-1:0]     blue;

    // Shadow copy of the stop registers that the predictor works from.
    logic [CFG_INDEX_W-1:0] shadow_stop_count;
    logic [STOP_W-1:0]      shadow_stops [STOP_REGS];

    logic [VALUE_W-1:0] pending_values [$];
    rgb_t               expected_colors [$];
    reg_write_t         reg_writes [$];

    // Flow-control knobs, changed by the stimulus only at a falling edge.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    multi_stop_color_gradient_core #(
        .MAX_STOPS     (MAX_STOPS),
        .VALUE_WIDTH   (VALUE_W),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Position field of a stop in the shadow registers.
    function automatic int unsigned stop_pos(int unsigned idx);
        return 32'(shadow_stops[idx][STOP_W-1:RGB_W]);
    endfunction

    // Predicts the color of one value from the shadow stop registers.
    function automatic rgb_t gradient_color(logic [VALUE_W-1:0] level);
        int unsigned used;
        int unsigned hi;
        int unsigned lo;
        int unsigned pos_v;
        int unsigned pos_lo;
        int unsigned pos_hi;
        int unsigned frac;
        int unsigned mix;
        logic [RGB_W-1:0] c_lo;
        logic [RGB_W-1:0] c_hi;
        logic [RGB_W-1:0] blended;
        used = 32'(shadow_stop_count);
        // A stop count outside 2..MAX_STOPS is pulled to the nearest bound.
        if (used < 2)
            used = 2;
        if (used > MAX_STOPS)
            used = MAX_STOPS;
        // Raise to the first position, then lower to the last one. With stops
        // out of order the second clamp wins.
        pos_v = 32'(level);
        if (pos_v < stop_pos(0))
            pos_v = stop_pos(0);
        if (pos_v > stop_pos(used - 1))
            pos_v = stop_pos(used - 1);
        // The upper end of the segment is the first stop past stop 0 whose
        // position lies above the value, so a zero-width segment never wins.
        hi = 0;
        for (int k = 1; k < used; k++)
        begin
            if (hi == 0 && stop_pos(k) > pos_v)
                hi = k;
        end
        if (hi == 0)
            return rgb_t'(shadow_stops[used - 1][RGB_W-1:0]);
        lo     = hi - 1;
        pos_lo = stop_pos(lo);
        pos_hi = stop_pos(hi);
        // A value below the lower stop can only happen with unordered stops;
        // it takes the lower color unchanged.
        if (pos_v < pos_lo)
            frac = 0;
        else
            frac = ((pos_v - pos_lo) << FRAC_BITS) / (pos_hi - pos_lo);
        if (frac > (1 << FRAC_BITS))
            frac = 1 << FRAC_BITS;
        c_lo = shadow_stops[lo][RGB_W-1:0];
        c_hi = shadow_stops[hi][RGB_W-1:0];
        for (int c = 0; c < 3; c++)
        begin
            mix = ((1 << FRAC_BITS) - frac) * 32'(c_lo[c*COLOR_W +: COLOR_W])
                + frac * 32'(c_hi[c*COLOR_W +: COLOR_W]) + (1 << (FRAC_BITS - 1));
            blended[c*COLOR_W +: COLOR_W] = COLOR_W'(mix >> FRAC_BITS);
        end
        return rgb_t'(blended);
    endfunction

    // Random value, leaning toward stop positions and the range ends, where
    // segment selection and clamping change.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] near;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                near = shadow_stops[$urandom_range(0, STOP_REGS - 1)][STOP_W-1:RGB_W];
                return near + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
            end
            3:
                return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default:
                return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic queue_write(logic [CFG_INDEX_W-1:0] idx, logic [STOP_W-1:0] data);
        reg_writes.push_back('{idx, data});
    endtask

    // Runs the queued register writes back to back on the configuration
    // channel. The shadow registers change at the edge that takes each write.
    task automatic apply_config();
        reg_write_t w;
        @(posedge clk);
        while (reg_writes.size() > 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            do
                @(posedge clk);
            while (!cfg_ready);
            if (w.index == REG_STOP_COUNT)
                shadow_stop_count = w.data[CFG_INDEX_W-1:0];
            else
                shadow_stops[w.index - REG_STOP_BASE] = w.data;
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits, at falling edges where every update has settled, until no value
    // is pending or offered and every expected color has come back.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_values.size() != 0 || in_valid || expected_colors.size() != 0);
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Input driver. The prediction is made at the edge that accepts a value,
    // while the shadow registers hold the setting that the core uses. A value
    // that is offered stays on the port until it is taken; the idle roll is
    // made only when a new value could be offered, so valid never follows
    // the stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_colors.push_back(gradient_color(value));
            if (!in_valid || !in_stall)
            begin
                if (pending_values.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    value    <= pending_values.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall. A hold request from the stimulus keeps the stall high for
    // a long stretch, so the pipeline fills and pushes back on the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Result monitor. Every accepted result is matched against the oldest
    // expected color, channel by channel.
    always @(posedge clk)
    begin : check_result
        rgb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_colors.size() == 0)
            begin
                report_mismatch($sformatf("result %02h%02h%02h with no value in flight",
                                          red, green, blue));
            end
            else
            begin
                want = expected_colors.pop_front();
                if (red !== want.red)
                    report_mismatch($sformatf("red %02h, expected %02h", red, want.red));
                if (green !== want.green)
                    report_mismatch($sformatf("green %02h, expected %02h", green, want.green));
                if (blue !== want.blue)
                    report_mismatch($sformatf("blue %02h, expected %02h", blue, want.blue));
            end
        end
    end

    // Watchdog: a run that hangs on a missing result ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned used;
        int unsigned pos;
        int unsigned step_max;
        logic [STOP_W-1:0] data;

        // Shadow registers start from the reset heat gradient.
        shadow_stop_count = STOP_COUNT_RESET;
        shadow_stops[0]   = {16'h0000, COLOR_GREEN};
        shadow_stops[1]   = {16'h8000, COLOR_YELLOW};
        shadow_stops[2]   = {16'hFFFF, COLOR_RED};
        for (int k = 3; k < STOP_REGS; k++)
            shadow_stops[k] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, under a light sender idle and a heavy output stall.
        send_idle_pct  = 13;
        recv_stall_pct = 59;

        // Reset gradient: both range ends, both sides of the middle stop.
        pending_values.push_back(16'h0000);
        pending_values.push_back(16'h0001);
        pending_values.push_back(16'h3FFF);
        pending_values.push_back(16'h7FFF);
        pending_values.push_back(16'h8000);
        pending_values.push_back(16'h8001);
        pending_values.push_back(16'hFFFE);
        pending_values.push_back(16'hFFFF);
        wait_until_drained();

        // All seven stops in use, spanning the whole range, with narrow
        // segments at both ends and colors at their extremes.
        queue_write(REG_STOP_COUNT, STOP_W'(MAX_STOPS));
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 0), {16'h0000, 24'hFFFFFF});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 1), {16'h0001, 24'h000000});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 2), {16'h0100, 24'hFFFFFF});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 3), {16'h7FFF, 24'hFF00FF});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 4), {16'h8000, 24'h000000});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 5), {16'hFFFE, 24'hFFFFFF});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 6), {16'hFFFF, 24'h00FF00});
        apply_config();
        @(negedge clk);
        pending_values.push_back(16'h0000);
        pending_values.push_back(16'h0001);
        pending_values.push_back(16'h0080);
        pending_values.push_back(16'h4000);
        pending_values.push_back(16'hFFFE);
        pending_values.push_back(16'hFFFF);
        wait_until_drained();

        // Stop count of zero acts as two. The first stop sits above the
        // second, so the value ends up at the last position and takes the
        // last color.
        queue_write(REG_STOP_COUNT, '0);
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 0), '1);
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 1), '0);
        apply_config();
        @(negedge clk);
        pending_values.push_back(16'h0000);
        pending_values.push_back(16'hFFFF);
        wait_until_drained();

        // Stop count of one acts as two: below the first stop, in the middle
        // and exactly at the last stop.
        queue_write(REG_STOP_COUNT, STOP_W'(1));
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 0), {16'h1000, 24'hFF0000});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 1), {16'h3000, 24'h0000FF});
        apply_config();
        @(negedge clk);
        pending_values.push_back(16'h0800);
        pending_values.push_back(16'h2000);
        pending_values.push_back(16'h3000);
        wait_until_drained();

        // Unordered stops where the clamped value lies below the lower stop
        // of the chosen segment, which gives the lower color as it is.
        queue_write(REG_STOP_COUNT, STOP_W'(3));
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 0), {16'h8000, 24'hFF0000});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 1), {16'h9000, 24'h00FF00});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 2), {16'h2000, 24'h0000FF});
        apply_config();
        @(negedge clk);
        pending_values.push_back(16'h0000);
        pending_values.push_back(16'h8800);
        wait_until_drained();

        // Stops with equal positions: the zero-width segments are skipped.
        queue_write(REG_STOP_COUNT, STOP_W'(5));
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 0), {16'h1000, 24'h102030});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 1), {16'h1000, 24'hF0E0D0});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 2), {16'h2000, 24'h00FF7F});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 3), {16'h2000, 24'h80FF01});
        queue_write(CFG_INDEX_W'(REG_STOP_BASE + 4), {16'h3000, 24'hFE0180});
        apply_config();
        @(negedge clk);
        pending_values.push_back(16'h1000);
        pending_values.push_back(16'h1800);
        pending_values.push_back(16'h2000);
        pending_values.push_back(16'h2800);
        wait_until_drained();

        // Random part. Each segment programs every register with a new
        // setting. Most settings are strictly ascending; every fifth one is
        // random data with a random count. The first third idles the sender
        // lightly and stalls the output heavily, the second third the other
        // way round, and the last third runs at full rate.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / (SEGMENTS / 3))
                0:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 59;
                end
                1:
                begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 13;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (seg == HOLD_SEG)
                hold_requests++;

            if (seg % 5 != 4)
            begin
                used = $urandom_range(2, MAX_STOPS);
                queue_write(REG_STOP_COUNT, STOP_W'(used));
                pos = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095);
                // Now and then the stops are packed tightly, which makes for
                // short segments and coarse fractions.
                if ($urandom_range(0, 3) == 0)
                    step_max = 8;
                else
                    step_max = (65535 - pos) / (used - 1);
                for (int k = 0; k < STOP_REGS; k++)
                begin
                    data = STOP_W'({$urandom, $urandom});
                    if (k < used)
                    begin
                        data[STOP_W-1:RGB_W] = VALUE_W'(pos);
                        if (k == used - 1 && $urandom_range(0, 3) == 0)
                            data[STOP_W-1:RGB_W] = '1;
                        pos += $urandom_range(1, step_max);
                    end
                    queue_write(CFG_INDEX_W'(REG_STOP_BASE + k), data);
                end
            end
            else
            begin
                queue_write(REG_STOP_COUNT, STOP_W'($urandom_range(0, 7)));
                for (int k = 0; k < STOP_REGS; k++)
                    queue_write(CFG_INDEX_W'(REG_STOP_BASE + k), STOP_W'({$urandom, $urandom}));
            end
            apply_config();
            @(negedge clk);

            for (int i = 0; i < ITEMS_PER_SEG; i++)
            begin
                // Halfway through one segment the sender stops until every
                // result is back, then carries on.
                if (seg == PAUSE_SEG && i == ITEMS_PER_SEG / 2)
                    wait_until_drained();
                pending_values.push_back(pick_value());
            end
            wait_until_drained();
        end

        // Give a stray result time to show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
